// File: src/lsr_pkg.sv
// Shared constants and codes for the slope-intercept line rasterizer.
// Used by the top level and the testbench; depends on nothing.
package lsr_pkg;

  // Default geometry.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int OFFSET_BITS    = 12;
  localparam int OUT_BITS       = 13;
  localparam int SLOPE_BITS     = 32;
  localparam int OUT_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

  // Quotient bits kept for the per-point division; larger values saturate anyway.
  localparam int PXQ_BITS       = 13;

  // Endpoint scaling.
  localparam int SCALE_LIMIT    = 10;
  localparam int SCALE_FACTOR   = 10;

  // Offset register reset values.
  localparam int OFFSET_X_RESET = 320;
  localparam int OFFSET_Y_RESET = 240;

  // Request codes carried in in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_Y = 2'd1;

endpackage

// File: src/lsr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; the top level supplies widths from its parameters.
module lsr_div #(
  parameter int DVW = 32,
  parameter int FW  = 35,
  parameter int CW  = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] divisor,
  input  logic [DVW-1:0] rem_init,  // must be below divisor
  input  logic [FW-1:0]  feed,      // dividend bits, most significant first
  input  logic [CW-1:0]  count,     // number of bits to shift in, at least one
  output logic           done,
  output logic [FW-1:0]  quot
);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DVW-1:0] d_r, d_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [FW-1:0]  feed_r, feed_nxt;
  logic [FW-1:0]  q_r, q_nxt;

  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem_r, feed_r[FW-1]};
    diff     = trial - {1'b0, d_r};
    fits     = (trial >= {1'b0, d_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    feed_nxt = feed_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = count;
      d_nxt    = divisor;
      rem_nxt  = rem_init;
      feed_nxt = feed;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DVW-1:0] : trial[DVW-1:0];
      feed_nxt = {feed_r[FW-2:0], 1'b0};
      q_nxt    = {q_r[FW-2:0], fits};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    feed_r <= feed_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/lsr_mul.sv
// Registered signed multiplier shared by the intercept and the x-major points.
// Stand-alone; widths come from the top level.
module lsr_mul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  logic signed [AW+BW-1:0] p_r;

  // Full product, registered.
  always_ff @(posedge clk) begin
    p_r <= (AW + BW)'(a) * (AW + BW)'(b);
  end

  assign p = p_r;

endmodule

// File: src/slope_intercept_line_rasterizer.sv
// Slope-intercept line rasterizer: load request sets up a line, step request emits a point.
// A load sets up the range, runs the slope divider unless dx is zero, then forms the intercept.
// An x-major step goes through the shared multiplier; a y-major step through the same divider
// unless x saturates; other steps go straight to the output.
// The block takes one request at a time; a result may wait in the output register meanwhile.
// Synchronous active-low reset clears the line state and sets the offsets to 320 and 240.
module slope_intercept_line_rasterizer #(
  parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lsr_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: x_start, y_start, x_finish, y_finish (COORD_BITS each), zero padded
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: op
  input  logic                                  in_tuser,
  // out_tdata: point_x, point_y (13 bits each), zero padded
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lsr_pkg::OUT_TDATA_BITS-1:0]    out_tdata,
  // out_tuser: point_valid
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [lsr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lsr_pkg::OFFSET_BITS-1:0]       cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = CB + 4;
  localparam int NM   = CB + 3 + F;
  localparam int SB   = lsr_pkg::SLOPE_BITS;
  localparam int PW   = SB + DW;
  localparam int IW   = PW + 1;
  localparam int SUMW = IW + 1;
  localparam int SATW = SUMW + 1;
  localparam int QB   = lsr_pkg::PXQ_BITS;
  localparam int OW   = lsr_pkg::OUT_BITS;
  localparam int OFW  = lsr_pkg::OFFSET_BITS;
  localparam int ODW  = lsr_pkg::OUT_TDATA_BITS;
  localparam int SQW  = NM + SB;
  localparam int CW   = $clog2(NM + 1);

  localparam logic [SQW-1:0] SMAG_MAX = (SQW'(1) << (SB - 1)) - SQW'(1);
  localparam logic [SQW-1:0] SMAG_MIN = SQW'(1) << (SB - 1);
  localparam logic signed [SB-1:0] SLOPE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SLOPE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SUMW-1:0] PX_CLAMP = {{(SUMW-QB){1'b0}}, {QB{1'b1}}};
  localparam logic signed [SATW-1:0] OUT_MAX = SATW'((2 ** (OW - 1)) - 1);
  localparam logic signed [SATW-1:0] OUT_MIN = SATW'(-(2 ** (OW - 1)));

  typedef enum logic [3:0] {
    S_IDLE, S_LD_PREP, S_LD_DIV, S_LD_MUL, S_LD_INT,
    S_X_MUL, S_X_SUM, S_Y_NUM, S_Y_CHK, S_Y_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Control registers.
  logic                   out_valid_r, out_valid_nxt;
  logic                   active_r, active_nxt;
  logic                   xmaj_r, xmaj_nxt;
  logic signed [OFW-1:0]  ox_r, ox_nxt;
  logic signed [OFW-1:0]  oy_r, oy_nxt;
  logic signed [SB-1:0]   slope_r, slope_nxt;
  logic signed [IW-1:0]   int_r, int_nxt;
  logic signed [DW-1:0]   pos_r, pos_nxt;
  logic signed [DW-1:0]   lim_r, lim_nxt;
  logic signed [DW-1:0]   anchor_r, anchor_nxt;

  // Datapath registers.
  logic [OW-1:0]          out_x_r, out_x_nxt;
  logic [OW-1:0]          out_y_r, out_y_nxt;
  logic                   out_pv_r, out_pv_nxt;
  logic                   out_last_r, out_last_nxt;
  logic signed [DW-1:0]   xs_r, xs_nxt;
  logic signed [DW-1:0]   ys_r, ys_nxt;
  logic signed [DW-1:0]   xe_r, xe_nxt;
  logic signed [DW-1:0]   ye_r, ye_nxt;
  logic                   sneg_r, sneg_nxt;
  logic [SUMW-1:0]        ymag_r, ymag_nxt;
  logic                   yneg_r, yneg_nxt;
  logic signed [SUMW-1:0] px_r, px_nxt;
  logic signed [SUMW-1:0] py_r, py_nxt;
  logic                   res_valid_r, res_valid_nxt;

  // Input fields.
  logic signed [CB-1:0]   in_xs, in_ys, in_xe, in_ye;
  logic                   small_all;
  logic                   in_fire;

  // Working values.
  logic signed [DW-1:0]   dx, dy;
  logic [DW-1:0]          dx_mag, dy_mag;
  logic [SQW-1:0]         sq_ext;
  logic signed [SUMW-1:0] x_sum, x_adj, y_num;
  logic [SUMW-1:0]        x_rnd;
  logic [SB-1:0]          smag;
  logic [SUMW-1:0]        y_hi;
  logic signed [SUMW-1:0] y_q;
  logic signed [SATW-1:0] sat_x, sat_y;
  logic                   is_last;

  // Shared units.
  logic                   div_start;
  logic [SB-1:0]          div_divisor, div_rem;
  logic [NM-1:0]          div_feed;
  logic [CW-1:0]          div_count;
  logic                   div_done;
  logic [NM-1:0]          div_q;
  logic signed [DW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;

  lsr_div #(
    .DVW(SB),
    .FW (NM),
    .CW (CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (div_divisor),
    .rem_init(div_rem),
    .feed    (div_feed),
    .count   (div_count),
    .done    (div_done),
    .quot    (div_q)
  );

  // The multiplier forms slope*x_start during the load and slope*x for x-major points.
  assign mul_b = (state_r == S_LD_MUL) ? anchor_r : pos_r;

  lsr_mul #(
    .AW(SB),
    .BW(DW)
  ) u_mul (
    .clk(clk),
    .a  (slope_r),
    .b  (mul_b),
    .p  (mul_p)
  );

  // Handshake and field unpacking.
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_xs     = in_tdata[CB-1:0];
  assign in_ys     = in_tdata[2*CB-1:CB];
  assign in_xe     = in_tdata[3*CB-1:2*CB];
  assign in_ye     = in_tdata[4*CB-1:3*CB];
  assign small_all = (in_xs < lsr_pkg::SCALE_LIMIT) && (in_ys < lsr_pkg::SCALE_LIMIT) &&
                     (in_xe < lsr_pkg::SCALE_LIMIT) && (in_ye < lsr_pkg::SCALE_LIMIT);

  // Arithmetic shared by the sequencer states.
  always_comb begin
    dx      = xe_r - xs_r;
    dy      = ye_r - ys_r;
    dx_mag  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    dy_mag  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    sq_ext  = SQW'(div_q);
    x_sum   = SUMW'(mul_p) + SUMW'(int_r);
    x_rnd   = {{(SUMW-F){1'b0}}, {F{x_sum[SUMW-1]}}};
    x_adj   = x_sum + $signed(x_rnd);
    y_num   = SUMW'($signed({pos_r, {F{1'b0}}})) - SUMW'(int_r);
    smag    = slope_r[SB-1] ? SB'(-slope_r) : SB'(slope_r);
    y_hi    = ymag_r >> QB;
    y_q     = $signed(SUMW'(div_q[QB-1:0]));
    sat_x   = SATW'(px_r) + SATW'(ox_r);
    sat_y   = SATW'(py_r) + SATW'(oy_r);
    is_last = (pos_r == lim_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    active_nxt    = active_r;
    xmaj_nxt      = xmaj_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    slope_nxt     = slope_r;
    int_nxt       = int_r;
    pos_nxt       = pos_r;
    lim_nxt       = lim_r;
    anchor_nxt    = anchor_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_pv_nxt    = out_pv_r;
    out_last_nxt  = out_last_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    sneg_nxt      = sneg_r;
    ymag_nxt      = ymag_r;
    yneg_nxt      = yneg_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    res_valid_nxt = res_valid_r;
    div_start     = 1'b0;
    div_divisor   = smag;
    div_rem       = '0;
    div_feed      = '0;
    div_count     = CW'(QB);

    // Offset register writes.
    if (cfg_we && (cfg_index == lsr_pkg::REG_OFFSET_X)) begin
      ox_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == lsr_pkg::REG_OFFSET_Y)) begin
      oy_nxt = cfg_wdata;
    end

    // A waiting result leaves when taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == lsr_pkg::OP_LOAD)) begin
          // Scale small endpoints up by ten.
          if (small_all) begin
            xs_nxt = DW'(in_xs * lsr_pkg::SCALE_FACTOR);
            ys_nxt = DW'(in_ys * lsr_pkg::SCALE_FACTOR);
            xe_nxt = DW'(in_xe * lsr_pkg::SCALE_FACTOR);
            ye_nxt = DW'(in_ye * lsr_pkg::SCALE_FACTOR);
          end else begin
            xs_nxt = DW'(in_xs);
            ys_nxt = DW'(in_ys);
            xe_nxt = DW'(in_xe);
            ye_nxt = DW'(in_ye);
          end
          state_nxt = S_LD_PREP;
        end else if (in_fire) begin
          if (!active_r) begin
            res_valid_nxt = 1'b0;
            state_nxt     = S_OUT;
          end else if (xmaj_r) begin
            state_nxt = S_X_MUL;
          end else if (slope_r == '0) begin
            // Flat slope on a y-major line: x stays at the anchor.
            res_valid_nxt = 1'b1;
            px_nxt        = SUMW'(anchor_r);
            py_nxt        = SUMW'(pos_r);
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_Y_NUM;
          end
        end
      end

      S_LD_PREP: begin
        // Major axis and range; start the slope division unless dx is zero.
        xmaj_nxt   = (dx > dy);
        anchor_nxt = xs_r;
        if (dx > dy) begin
          pos_nxt    = xs_r;
          lim_nxt    = xe_r;
          active_nxt = (xs_r <= xe_r);
        end else begin
          pos_nxt    = ys_r;
          lim_nxt    = ye_r - DW'(1);
          active_nxt = (ys_r <= ye_r - DW'(1));
        end
        sneg_nxt = dx[DW-1] ^ dy[DW-1];
        if (dx == '0) begin
          slope_nxt = '0;
          state_nxt = S_LD_MUL;
        end else begin
          div_start   = 1'b1;
          div_divisor = SB'(dx_mag);
          div_rem     = '0;
          div_feed    = {dy_mag[CB+2:0], {F{1'b0}}};
          div_count   = CW'(NM);
          state_nxt   = S_LD_DIV;
        end
      end

      S_LD_DIV: begin
        // Signed, saturated slope from the quotient magnitude.
        if (div_done) begin
          if (!sneg_r) begin
            slope_nxt = (sq_ext > SMAG_MAX) ? SLOPE_MAX : $signed(SB'(div_q));
          end else begin
            slope_nxt = (sq_ext > SMAG_MIN) ? SLOPE_MIN : $signed(SB'(-sq_ext));
          end
          state_nxt = S_LD_MUL;
        end
      end

      S_LD_MUL: begin
        state_nxt = S_LD_INT;
      end

      S_LD_INT: begin
        // Intercept is y_start in fixed point minus slope times x_start.
        int_nxt   = IW'($signed({ys_r, {F{1'b0}}})) - IW'(mul_p);
        state_nxt = S_IDLE;
      end

      S_X_MUL: begin
        state_nxt = S_X_SUM;
      end

      S_X_SUM: begin
        // y = (slope*x + intercept) / 2^F, truncated toward zero.
        res_valid_nxt = 1'b1;
        px_nxt        = SUMW'(pos_r);
        py_nxt        = x_adj >>> F;
        state_nxt     = S_OUT;
      end

      S_Y_NUM: begin
        ymag_nxt  = y_num[SUMW-1] ? SUMW'(-y_num) : SUMW'(y_num);
        yneg_nxt  = y_num[SUMW-1] ^ slope_r[SB-1];
        state_nxt = S_Y_CHK;
      end

      S_Y_CHK: begin
        // A quotient too large for the output saturates without dividing.
        res_valid_nxt = 1'b1;
        py_nxt        = SUMW'(pos_r);
        if (y_hi >= SUMW'(smag)) begin
          px_nxt    = yneg_r ? -PX_CLAMP : PX_CLAMP;
          state_nxt = S_OUT;
        end else begin
          div_start   = 1'b1;
          div_divisor = smag;
          div_rem     = SB'(y_hi);
          div_feed    = {ymag_r[QB-1:0], {(NM-QB){1'b0}}};
          div_count   = CW'(QB);
          state_nxt   = S_Y_DIV;
        end
      end

      S_Y_DIV: begin
        if (div_done) begin
          px_nxt    = yneg_r ? -y_q : y_q;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // Load the result once the output register is free; a valid point also advances the line.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pv_nxt    = res_valid_r;
          if (res_valid_r) begin
            if (sat_x > OUT_MAX) begin
              out_x_nxt = OW'(OUT_MAX);
            end else if (sat_x < OUT_MIN) begin
              out_x_nxt = OW'(OUT_MIN);
            end else begin
              out_x_nxt = OW'(sat_x);
            end
            if (sat_y > OUT_MAX) begin
              out_y_nxt = OW'(OUT_MAX);
            end else if (sat_y < OUT_MIN) begin
              out_y_nxt = OW'(OUT_MIN);
            end else begin
              out_y_nxt = OW'(sat_y);
            end
            out_last_nxt = is_last;
            pos_nxt      = pos_r + DW'(1);
            if (is_last) begin
              active_nxt = 1'b0;
            end
          end else begin
            out_x_nxt    = '0;
            out_y_nxt    = '0;
            out_last_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and line registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      xmaj_r      <= 1'b0;
      ox_r        <= OFW'(lsr_pkg::OFFSET_X_RESET);
      oy_r        <= OFW'(lsr_pkg::OFFSET_Y_RESET);
      slope_r     <= '0;
      int_r       <= '0;
      pos_r       <= '0;
      lim_r       <= '0;
      anchor_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      xmaj_r      <= xmaj_nxt;
      ox_r        <= ox_nxt;
      oy_r        <= oy_nxt;
      slope_r     <= slope_nxt;
      int_r       <= int_nxt;
      pos_r       <= pos_nxt;
      lim_r       <= lim_nxt;
      anchor_r    <= anchor_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_pv_r    <= out_pv_nxt;
    out_last_r  <= out_last_nxt;
    xs_r        <= xs_nxt;
    ys_r        <= ys_nxt;
    xe_r        <= xe_nxt;
    ye_r        <= ye_nxt;
    sneg_r      <= sneg_nxt;
    ymag_r      <= ymag_nxt;
    yneg_r      <= yneg_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    res_valid_r <= res_valid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ODW-2*OW){1'b0}}, out_y_r, out_x_r};
  assign out_tuser  = out_pv_r;
  assign out_tlast  = out_last_r;

endmodule

// File: tb/line_point_checker.sv
// Point checker for the slope-intercept line rasterizer testbench.
// Watches the request, result and register ports, predicts every point and compares it.
// Depends on lsr_pkg for field widths, request codes and register indexes.
module line_point_checker #(
  parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lsr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  // in_tdata: x_start, y_start, x_finish, y_finish (COORD_BITS each), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  // in_tuser: op
  input  logic                                 in_tuser,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: point_x, point_y (13 bits each), zero padded
  input  logic [lsr_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  // out_tuser: point_valid
  input  logic                                 out_tuser,
  input  logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [lsr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [lsr_pkg::OFFSET_BITS-1:0]      cfg_wdata,
  output int                                   mismatches,
  output int                                   pending
);

  localparam int     OUT_BITS  = lsr_pkg::OUT_BITS;
  localparam longint UNIT      = longint'(1) << FRAC_BITS;
  localparam longint SLOPE_MAX = (longint'(1) << (lsr_pkg::SLOPE_BITS - 1)) - 1;
  localparam longint SLOPE_MIN = -(longint'(1) << (lsr_pkg::SLOPE_BITS - 1));
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       valid;
    logic                       last;
  } point_t;

  // Points still owed by the block, oldest first.
  point_t expected_points[$];

  // Predicted line state and offset registers.
  longint offset_x, offset_y;
  longint slope_q, intercept_q;
  longint major_pos, major_end, anchor_x;
  bit     x_major, drawing;

  // Adds nothing; clamps an offset coordinate into the output range.
  function automatic logic signed [OUT_BITS-1:0] clip_out(longint v);
    longint hi, lo;
    hi = (longint'(1) << (OUT_BITS - 1)) - 1;
    lo = -(longint'(1) << (OUT_BITS - 1));
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[OUT_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    longint xs, ys, xe, ye, dx, dy, px, py;
    point_t got, want;
    if (!rst_n) begin
      offset_x    = lsr_pkg::OFFSET_X_RESET;
      offset_y    = lsr_pkg::OFFSET_Y_RESET;
      slope_q     = 0;
      intercept_q = 0;
      major_pos   = 0;
      major_end   = 0;
      anchor_x    = 0;
      x_major     = 1'b0;
      drawing     = 1'b0;
      expected_points.delete();
    end else begin
      // Compare each accepted point with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[OUT_BITS-1:0];
        got.y     = out_tdata[2*OUT_BITS-1:OUT_BITS];
        got.valid = out_tuser;
        got.last  = out_tlast;
        if (expected_points.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: point with none expected: x=%0d y=%0d valid=%0b last=%0b",
                     $time, $signed(got.x), $signed(got.y), got.valid, got.last);
          end
          mismatches = mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y ||
              got.valid !== want.valid || got.last !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: point mismatch: expected x=%0d y=%0d valid=%0b last=%0b",
                       $time, $signed(want.x), $signed(want.y), want.valid, want.last);
              $display("%0t:                 actual   x=%0d y=%0d valid=%0b last=%0b",
                       $time, $signed(got.x), $signed(got.y), got.valid, got.last);
            end
            mismatches = mismatches + 1;
          end
        end
      end

      // Track offset register writes; other indexes are ignored by the block.
      if (cfg_we) begin
        if (cfg_index == lsr_pkg::REG_OFFSET_X) begin
          offset_x = longint'($signed(cfg_wdata));
        end else if (cfg_index == lsr_pkg::REG_OFFSET_Y) begin
          offset_y = longint'($signed(cfg_wdata));
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == lsr_pkg::OP_LOAD) begin
          // Line setup: optional scaling, slope, intercept and major axis.
          xs = longint'($signed(in_tdata[COORD_BITS-1:0]));
          ys = longint'($signed(in_tdata[2*COORD_BITS-1:COORD_BITS]));
          xe = longint'($signed(in_tdata[3*COORD_BITS-1:2*COORD_BITS]));
          ye = longint'($signed(in_tdata[4*COORD_BITS-1:3*COORD_BITS]));
          if (xs < lsr_pkg::SCALE_LIMIT && xe < lsr_pkg::SCALE_LIMIT &&
              ys < lsr_pkg::SCALE_LIMIT && ye < lsr_pkg::SCALE_LIMIT) begin
            xs = xs * lsr_pkg::SCALE_FACTOR;
            xe = xe * lsr_pkg::SCALE_FACTOR;
            ys = ys * lsr_pkg::SCALE_FACTOR;
            ye = ye * lsr_pkg::SCALE_FACTOR;
          end
          dx = xe - xs;
          dy = ye - ys;
          slope_q = 0;
          if (dx != 0) begin
            slope_q = (dy * UNIT) / dx;
          end
          if (slope_q > SLOPE_MAX) begin
            slope_q = SLOPE_MAX;
          end else if (slope_q < SLOPE_MIN) begin
            slope_q = SLOPE_MIN;
          end
          intercept_q = ys * UNIT - slope_q * xs;
          anchor_x    = xs;
          x_major     = dx > dy;
          if (x_major) begin
            major_pos = xs;
            major_end = xe;
          end else begin
            major_pos = ys;
            major_end = ye - 1;
          end
          drawing = major_pos <= major_end;
        end else if (!drawing || major_pos > major_end) begin
          // No line left: an all-zero result.
          drawing = 1'b0;
          want    = '0;
          expected_points.push_back(want);
        end else begin
          // Next point along the major axis, truncating toward zero.
          if (x_major) begin
            px = major_pos;
            py = (slope_q * px + intercept_q) / UNIT;
          end else begin
            py = major_pos;
            if (slope_q == 0) begin
              px = anchor_x;
            end else begin
              px = (py * UNIT - intercept_q) / slope_q;
            end
          end
          want.x     = clip_out(px + offset_x);
          want.y     = clip_out(py + offset_y);
          want.valid = 1'b1;
          want.last  = major_pos == major_end;
          expected_points.push_back(want);
          if (want.last) begin
            drawing = 1'b0;
          end
          major_pos = major_pos + 1;
        end
      end
    end
    pending <= expected_points.size();
  end

endmodule

// File: tb/slope_intercept_line_rasterizer_tb.sv
// Top of the line rasterizer testbench: clock, reset, request and register stimulus.
// Instantiates slope_intercept_line_rasterizer and line_point_checker; uses lsr_pkg.
module slope_intercept_line_rasterizer_tb;

  localparam int COORD_BITS    = lsr_pkg::COORD_BITS_DEF;
  localparam int FRAC_BITS     = lsr_pkg::FRAC_BITS_DEF;
  localparam int IN_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASES        = 4;
  // A line setup produces no point, so wait out the slope divider before idling.
  localparam int SETTLE_CYCLES = COORD_BITS + FRAC_BITS + 7 + 25;
  localparam int STALL_CYCLES  = 200;
  localparam logic [lsr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  // in_tdata: x_start, y_start, x_finish, y_finish (COORD_BITS each), zero padded
  logic [IN_TDATA_BITS-1:0]            in_tdata;
  // in_tuser: op
  logic                                in_tuser;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  // out_tdata: point_x, point_y (13 bits each), zero padded
  logic [lsr_pkg::OUT_TDATA_BITS-1:0]  out_tdata;
  // out_tuser: point_valid
  logic                                out_tuser;
  logic                                out_tlast;
  logic                                cfg_we;
  logic [lsr_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
  logic [lsr_pkg::OFFSET_BITS-1:0]     cfg_wdata;

  int mismatches;
  int pending;
  int sent_count = 0;
  bit calm       = 1'b0;
  bit squeeze    = 1'b0;
  bit squeeze_done = 1'b0;
  int hold_left  = 0;

  slope_intercept_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  line_point_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) point_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, one long hold-off while the squeeze phase runs.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (squeeze && !squeeze_done) begin
      hold_left    <= STALL_CYCLES;
      squeeze_done <= 1'b1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(input logic op, input int xs, input int ys,
                              input int xe, input int ye);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_BITS'({COORD_BITS'(ye), COORD_BITS'(xe),
                                 COORD_BITS'(ys), COORD_BITS'(xs)});
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  task automatic step_points(input int count);
    repeat (count) send_request(lsr_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Lets every point drain and the block go quiet, then rewrites the offsets.
  task automatic set_offsets(input int ox, input int oy);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lsr_pkg::REG_OFFSET_X;
    cfg_wdata <= lsr_pkg::OFFSET_BITS'(ox);
    @(posedge clk);
    cfg_index <= lsr_pkg::REG_OFFSET_Y;
    cfg_wdata <= lsr_pkg::OFFSET_BITS'(oy);
    @(posedge clk);
    // A write beyond the register list must leave both offsets alone.
    cfg_index <= REG_SPARE;
    cfg_wdata <= lsr_pkg::OFFSET_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short lines followed by steps that often run past the end, plus noise.
  task automatic random_line();
    int pick, xs, ys, xe, ye;
    pick = $urandom_range(99);
    if (pick < 80) begin
      if (pick < 45) begin
        xs = int'($urandom_range(4095)) - 2048;
        ys = int'($urandom_range(4095)) - 2048;
        xe = xs + int'($urandom_range(8)) - 4;
        ye = ys + int'($urandom_range(8)) - 4;
      end else if (pick < 65) begin
        // Near the origin, where the endpoints usually get scaled up.
        xs = int'($urandom_range(24)) - 15;
        ys = int'($urandom_range(24)) - 15;
        xe = xs + int'($urandom_range(4)) - 2;
        ye = ys + int'($urandom_range(4)) - 2;
      end else begin
        xs = $urandom;
        ys = $urandom;
        xe = $urandom;
        ye = $urandom;
      end
      send_request(lsr_pkg::OP_LOAD, xs, ys, xe, ye);
      step_points($urandom_range(12));
    end else begin
      send_request(logic'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tuser  <= lsr_pkg::OP_STEP;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= lsr_pkg::REG_OFFSET_X;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset offsets.
    step_points(1);                                           // step with no line loaded
    send_request(lsr_pkg::OP_LOAD, 10, 20, 12, 21);           // x-major, three points
    step_points(4);
    send_request(lsr_pkg::OP_LOAD, 10, 10, 11, 13);           // y-major, three points
    step_points(4);
    send_request(lsr_pkg::OP_LOAD, 20, 10, 20, 12);           // vertical: zero dx
    step_points(2);
    send_request(lsr_pkg::OP_LOAD, 10, 30, 11, 30);           // horizontal: zero dy
    step_points(2);
    send_request(lsr_pkg::OP_LOAD, 15, 15, 12, 12);           // backward range, no points
    step_points(1);
    send_request(lsr_pkg::OP_LOAD, 9, -5, 9, -4);             // small endpoints get scaled
    step_points(1);
    send_request(lsr_pkg::OP_LOAD, -2048, -2048, 2047, 2047); // full-range diagonal
    step_points(1);
    send_request(lsr_pkg::OP_LOAD, -2048, 2047, 2047, -2048); // full-range falling line
    step_points(1);

    // Random lines under several offset settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_offsets(2047, 2047);
        1: set_offsets(-2048, -2048);
        2: set_offsets(0, 0);
        default: set_offsets(int'($urandom_range(4095)) - 2048,
                             int'($urandom_range(4095)) - 2048);
      endcase
      calm    <= (phase == 1);
      squeeze <= (phase == 2);
      while (sent_count < 25 + PHASE_ITEMS * (phase + 1)) random_line();
    end

    // Drain the last points and give the block time to go quiet.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit: many times the slowest legal run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
